/* hw/rtl/gba_pkg.sv */
`timescale 1ns / 1ps
// gba_pkg: shared codes, field widths and controller/datapath interface structs
// for the grouped bitmap allocator; no dependencies
package gba_pkg;

    // field widths
    localparam int GS_W   = 14;
    localparam int TC_W   = 17;
    localparam int NUM_W  = 32;
    localparam int GF_W   = 14;
    localparam int TF_W   = 17;
    localparam int GIDX_W = 3;
    localparam int WIDX_W = 7;
    localparam int LD_W   = 64;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 64;

    // operation modes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LDWORD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LDGRP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LDTOT  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GROUP_SIZE = 2'd0;
    localparam logic [1:0] REG_TOTAL      = 2'd1;
    localparam logic [1:0] REG_BASE       = 2'd2;
    localparam logic [1:0] REG_LOWEST     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic clr_step;
        logic grp_init;
        logic grp_next;
        logic scan_init;
        logic scan_step;
        logic alloc_commit;
        logic res_fail;
        logic res_bad;
        logic div_init;
        logic div_step;
        logic free_rd;
        logic free_commit;
        logic exec_load;
        logic push;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic clr_last;
        logic grp_stop;
        logic grp_empty;
        logic hit;
        logic scan_idle;
        logic free_bad;
        logic div_done;
        logic div_ovf;
    } t_dp_stat;

endpackage

/* hw/rtl/gba_ram.sv */
`timescale 1ns / 1ps
// gba_ram: generic single write port, single read port ram with registered read
// no dependencies
module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gba_datapath.sv */
`timescale 1ns / 1ps
// gba_datapath: counts, scan counters, group divider, result registers and bitmap
// ram access; uses gba_pkg, driven by gba_ctrl
module gba_datapath import gba_pkg::*; #(
    parameter int MAX_GROUP_BITS = 8192,
    parameter int MAX_GROUPS     = 8,
    parameter int WORD_BITS      = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    // input word fields
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [NUM_W-1:0]       i_item_number,
    input  logic [GIDX_W-1:0]      i_group_index,
    input  logic [WIDX_W-1:0]      i_word_index,
    input  logic [LD_W-1:0]        i_load_data,
    // configuration
    input  logic [GS_W-1:0]        i_group_size,
    input  logic [TC_W-1:0]        i_total_count,
    input  logic [NUM_W-1:0]       i_number_base,
    input  logic [NUM_W-1:0]       i_lowest_freeable,
    // bitmap ram
    output logic                   o_ram_we,
    output logic [$clog2(MAX_GROUPS*(MAX_GROUP_BITS/WORD_BITS))-1:0] o_ram_waddr,
    output logic [WORD_BITS-1:0]   o_ram_wdata,
    output logic [$clog2(MAX_GROUPS*(MAX_GROUP_BITS/WORD_BITS))-1:0] o_ram_raddr,
    input  logic [WORD_BITS-1:0]   i_ram_rdata,
    // result word fields
    output logic [NUM_W-1:0]       o_alloc_number,
    output logic [STAT_W-1:0]      o_status,
    output logic [GF_W-1:0]        o_group_free,
    output logic [TF_W-1:0]        o_total_free
);

    localparam int WPG  = MAX_GROUP_BITS / WORD_BITS;
    localparam int TOTAL_WORDS = MAX_GROUPS * WPG;
    localparam int AW   = $clog2(TOTAL_WORDS);
    localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int QW   = $clog2(MAX_GROUPS + 1);
    localparam int WW   = $clog2(WPG + 1);
    localparam int BW   = $clog2(WORD_BITS);
    localparam int PW   = $clog2(WORD_BITS + 1);
    localparam int OW   = $clog2(MAX_GROUP_BITS + 1);
    localparam int GCOUNT_LIM = (MAX_GROUP_BITS < 16383) ? MAX_GROUP_BITS : 16383;
    localparam int TCOUNT_LIM = (MAX_GROUPS * MAX_GROUP_BITS < 131071) ?
                                (MAX_GROUPS * MAX_GROUP_BITS) : 131071;

    // latched input word
    logic [MODE_W-1:0]    r_mode;
    logic [NUM_W-1:0]     r_num;
    logic [GIDX_W-1:0]    r_in_grp;
    logic [WIDX_W-1:0]    r_wi;
    logic [LD_W-1:0]      r_data;

    // work registers
    logic [QW-1:0]        r_grp;
    logic [NUM_W-1:0]     r_gbase;
    logic [GS_W-1:0]      r_left;
    logic [WW-1:0]        r_wrd;
    logic                 r_pv;
    logic [PW-1:0]        r_pleft;
    logic [WW-1:0]        r_pwrd;
    logic [WORD_BITS-1:0] r_hit_word;
    logic [AW-1:0]        r_hit_addr;
    logic [OW-1:0]        r_hit_off;
    logic [TC_W-1:0]      r_rem;
    logic [AW-1:0]        r_clr;
    logic [GF_W-1:0]      r_cnt [MAX_GROUPS];
    logic [TF_W-1:0]      r_tot;

    // staged and output result
    logic [NUM_W-1:0]     r_st_num;
    logic [STAT_W-1:0]    r_st_stat;
    logic [GF_W-1:0]      r_st_gf;
    logic [NUM_W-1:0]     r_o_num;
    logic [STAT_W-1:0]    r_o_stat;
    logic [GF_W-1:0]      r_o_gf;
    logic [TF_W-1:0]      r_o_tf;

    logic [GS_W-1:0]      gs_eff;
    logic [GW-1:0]        cnt_idx;
    logic [GF_W-1:0]      cnt_cur;
    logic [NUM_W-1:0]     span;
    logic [GS_W-1:0]      left_init;
    logic                 issue;
    logic [GS_W-1:0]      take;
    logic [AW-1:0]        scan_addr;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] look;
    logic                 zfound;
    logic [BW-1:0]        zbit;
    logic                 hit;
    logic                 div_ge;
    logic [AW-1:0]        free_addr;
    logic [AW-1:0]        ld_addr;
    logic                 grp_ok;
    logic                 wi_ok;
    logic [GF_W-1:0]      gclamp;
    logic [TF_W-1:0]      tclamp;
    logic [NUM_W-1:0]     idx_full;

    // effective group size, zero acts as one, clamp to storage
    always_comb begin
        if (i_group_size == '0) begin
            gs_eff = GS_W'(1);
        end else if (32'(i_group_size) > 32'(MAX_GROUP_BITS)) begin
            gs_eff = GS_W'(MAX_GROUP_BITS);
        end else begin
            gs_eff = i_group_size;
        end
    end

    assign cnt_idx = r_grp[GW-1:0];
    assign cnt_cur = r_cnt[cnt_idx];

    // bits of the current group that lie below the total count
    assign span      = 32'(i_total_count) - r_gbase;
    assign left_init = (span < 32'(gs_eff)) ? span[GS_W-1:0] : gs_eff;

    // scan issue side
    assign issue     = (r_left != '0);
    assign take      = (r_left > GS_W'(WORD_BITS)) ? GS_W'(WORD_BITS) : r_left;
    assign scan_addr = AW'(32'(r_grp) * WPG + 32'(r_wrd));

    // scan check side: lowest clear valid bit of the returned word
    always_comb begin
        if (r_pleft == PW'(WORD_BITS)) begin
            vmask = '1;
        end else begin
            vmask = (WORD_BITS'(1) << r_pleft) - WORD_BITS'(1);
        end
    end

    assign look = i_ram_rdata | ~vmask;

    always_comb begin
        zfound = 1'b0;
        zbit   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!look[i]) begin
                zfound = 1'b1;
                zbit   = BW'(i);
            end
        end
    end

    assign hit = r_pv && zfound;

    // free path: range check and group divider by repeated subtraction
    assign idx_full  = r_num - i_number_base;
    assign div_ge    = (r_rem >= TC_W'(gs_eff));
    assign free_addr = AW'(32'(r_grp) * WPG + 32'(r_rem >> BW));

    // load path
    assign grp_ok  = (32'(r_in_grp) < MAX_GROUPS);
    assign wi_ok   = (32'(r_wi) < WPG);
    assign ld_addr = AW'(32'(r_in_grp) * WPG + 32'(r_wi));
    assign gclamp  = (r_data > 64'(GCOUNT_LIM)) ? GF_W'(GCOUNT_LIM) : r_data[GF_W-1:0];
    assign tclamp  = (r_data > 64'(TCOUNT_LIM)) ? TF_W'(TCOUNT_LIM) : r_data[TF_W-1:0];

    // status to controller
    always_comb begin
        o_stat           = '0;
        o_stat.mode      = r_mode;
        o_stat.clr_last  = (r_clr == AW'(TOTAL_WORDS - 1));
        o_stat.grp_stop  = (r_grp == QW'(MAX_GROUPS)) || (r_gbase >= 32'(i_total_count));
        o_stat.grp_empty = (cnt_cur == '0);
        o_stat.hit       = hit;
        o_stat.scan_idle = !r_pv && !issue;
        o_stat.free_bad  = (r_num < i_lowest_freeable) || (r_num < i_number_base) ||
                           (idx_full >= 32'(i_total_count));
        o_stat.div_done  = !div_ge;
        o_stat.div_ovf   = div_ge && (r_grp == QW'(MAX_GROUPS - 1));
    end

    // ram ports
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_hit_addr;
        o_ram_wdata = r_hit_word;
        if (i_cmd.clr_step) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_clr;
            o_ram_wdata = '0;
        end else if (i_cmd.alloc_commit) begin
            o_ram_we    = 1'b1;
        end else if (i_cmd.free_commit) begin
            o_ram_we    = 1'b1;
            o_ram_wdata = i_ram_rdata & ~(WORD_BITS'(1) << r_rem[BW-1:0]);
        end else if (i_cmd.exec_load && (r_mode == MODE_LDWORD) && grp_ok && wi_ok) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = ld_addr;
            o_ram_wdata = r_data[WORD_BITS-1:0];
        end
    end

    assign o_ram_raddr = i_cmd.scan_step ? scan_addr : free_addr;

    // control state: clear pointer, scan pending flag, counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_pv  <= 1'b0;
            r_tot <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_cnt[g] <= '0;
            end
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.scan_init) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pv <= issue;
            end
            if (i_cmd.alloc_commit) begin
                r_cnt[cnt_idx] <= cnt_cur - GF_W'(1);
                if (r_tot != '0) begin
                    r_tot <= r_tot - TF_W'(1);
                end
            end
            if (i_cmd.free_commit) begin
                if (32'(cnt_cur) < GCOUNT_LIM) begin
                    r_cnt[cnt_idx] <= cnt_cur + GF_W'(1);
                end
                if (32'(r_tot) < TCOUNT_LIM) begin
                    r_tot <= r_tot + TF_W'(1);
                end
            end
            if (i_cmd.exec_load) begin
                if ((r_mode == MODE_LDGRP) && grp_ok) begin
                    r_cnt[cnt_idx] <= gclamp;
                end
                if (r_mode == MODE_LDTOT) begin
                    r_tot <= tclamp;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode   <= i_mode;
            r_num    <= i_item_number;
            r_in_grp <= i_group_index;
            r_wi     <= i_word_index;
            r_data   <= i_load_data;
            r_grp    <= QW'(i_group_index);
        end
        if (i_cmd.grp_init || i_cmd.div_init) begin
            r_grp   <= '0;
            r_gbase <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem <= TC_W'(idx_full);
        end
        if (i_cmd.div_step && div_ge) begin
            r_rem <= r_rem - TC_W'(gs_eff);
            r_grp <= r_grp + QW'(1);
        end
        if (i_cmd.grp_next) begin
            r_grp   <= r_grp + QW'(1);
            r_gbase <= r_gbase + 32'(gs_eff);
        end
        if (i_cmd.scan_init) begin
            r_left <= left_init;
            r_wrd  <= '0;
        end
        if (i_cmd.scan_step) begin
            if (issue) begin
                r_pleft <= PW'(take);
                r_pwrd  <= r_wrd;
                r_wrd   <= r_wrd + WW'(1);
                r_left  <= r_left - take;
            end
            if (hit) begin
                r_hit_word <= i_ram_rdata | (WORD_BITS'(1) << zbit);
                r_hit_addr <= AW'(32'(r_grp) * WPG + 32'(r_pwrd));
                r_hit_off  <= OW'(32'(r_pwrd) * WORD_BITS + 32'(zbit));
            end
        end
        if (i_cmd.free_rd) begin
            r_hit_addr <= free_addr;
        end
        // staged result
        if (i_cmd.alloc_commit) begin
            r_st_num  <= r_gbase + i_number_base + 32'(r_hit_off);
            r_st_stat <= STAT_OK;
            r_st_gf   <= cnt_cur - GF_W'(1);
        end
        if (i_cmd.res_fail) begin
            r_st_num  <= '0;
            r_st_stat <= STAT_NOFREE;
            r_st_gf   <= '0;
        end
        if (i_cmd.res_bad) begin
            r_st_num  <= '0;
            r_st_stat <= STAT_RANGE;
            r_st_gf   <= '0;
        end
        if (i_cmd.free_commit) begin
            r_st_num  <= '0;
            r_st_stat <= STAT_OK;
            r_st_gf   <= (32'(cnt_cur) < GCOUNT_LIM) ? cnt_cur + GF_W'(1) : cnt_cur;
        end
        if (i_cmd.exec_load) begin
            r_st_num  <= '0;
            r_st_stat <= STAT_OK;
            case (r_mode)
                MODE_LDWORD: r_st_gf <= (grp_ok && wi_ok) ? cnt_cur : '0;
                MODE_LDGRP:  r_st_gf <= grp_ok ? gclamp : '0;
                default:     r_st_gf <= '0;
            endcase
        end
        // output register
        if (i_cmd.push) begin
            r_o_num  <= r_st_num;
            r_o_stat <= r_st_stat;
            r_o_gf   <= r_st_gf;
            r_o_tf   <= r_tot;
        end
    end

    assign o_alloc_number = r_o_num;
    assign o_status       = r_o_stat;
    assign o_group_free   = r_o_gf;
    assign o_total_free   = r_o_tf;

    // an allocation only commits in a group with free items
    a_alloc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_commit |-> (cnt_cur != '0))
        else $error("allocation committed in an empty group");

    // divider quotient stays inside storage
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (32'(r_grp) < MAX_GROUPS))
        else $error("divider quotient beyond group storage");

    // global count never exceeds its limit
    a_tot_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (32'(r_tot) <= TCOUNT_LIM))
        else $error("global free count above limit");

endmodule

/* hw/rtl/gba_ctrl.sv */
`timescale 1ns / 1ps
// gba_ctrl: controller state machine for the grouped bitmap allocator
// uses gba_pkg, commands gba_datapath
module gba_ctrl import gba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_AGRP  = 4'd3;
    localparam logic [3:0] S_ASCAN = 4'd4;
    localparam logic [3:0] S_AWR   = 4'd5;
    localparam logic [3:0] S_FDIV  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.mode)
                    MODE_ALLOC: begin
                        o_cmd.grp_init = 1'b1;
                        n_state        = S_AGRP;
                    end
                    MODE_FREE: begin
                        if (i_stat.free_bad) begin
                            o_cmd.res_bad = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_state        = S_FDIV;
                        end
                    end
                    default: begin
                        o_cmd.exec_load = 1'b1;
                        n_state         = S_DONE;
                    end
                endcase
            end
            S_AGRP: begin
                if (i_stat.grp_stop) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.grp_empty) begin
                    o_cmd.grp_next = 1'b1;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_ASCAN;
                end
            end
            S_ASCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_AWR;
                end else if (i_stat.scan_idle) begin
                    o_cmd.grp_next = 1'b1;
                    n_state        = S_AGRP;
                end
            end
            S_AWR: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = S_DONE;
            end
            S_FDIV: begin
                if (i_stat.div_ovf) begin
                    o_cmd.res_bad = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.div_done) begin
                    o_cmd.free_rd = 1'b1;
                    n_state       = S_FRD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FRD: begin
                o_cmd.free_commit = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_ovalid;

    // a hit write always follows the scan
    a_awr_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWR) |-> ($past(r_state) == S_ASCAN))
        else $error("allocation write without scan");

    // free write follows its ram read
    a_frd_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> ($past(r_state) == S_FDIV))
        else $error("free commit without read");

    // a finished result waits while the output is still held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !i_m_ready) |=> (r_state == S_DONE))
        else $error("result overwrote a held output");

endmodule

/* hw/rtl/grouped_bitmap_allocator_core.sv */
`timescale 1ns / 1ps
// grouped_bitmap_allocator_core: top level with configuration registers
// uses gba_pkg, gba_ctrl, gba_datapath, gba_ram
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tdata: item_number, group_index, word_index,
//                                          load_data; tuser: mode
// m_*       out  m_tvalid / m_tready       tdata: alloc_number, group_free, total_free;
//                                          tuser: status
// apb       in   psel, penable, pwrite     paddr 4*i: group_size, total_count,
//                                          number_base, lowest_freeable
//
// after reset the bitmap ram is cleared one word a cycle (all 1024 words, s_tready low)
// allocate: groups are visited in order, empty ones are skipped, and the bitmap words of
// each nonempty group are scanned for the lowest clear bit
// free: range check, group found by the subtracting divider, then the word is read and the bit cleared
// loads and other modes go straight to the result; one item is worked at a time
// the next word is taken while a result waits in the output register
module grouped_bitmap_allocator_core import gba_pkg::*; #(
    parameter int MAX_GROUP_BITS = 8192,
    parameter int MAX_GROUPS     = 8,
    parameter int WORD_BITS      = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // item_number[31:0], group_index[34:32], word_index[41:35], load_data[105:42]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // alloc_number[31:0], group_free[45:32], total_free[62:46]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]    m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int TOTAL_WORDS = MAX_GROUPS * (MAX_GROUP_BITS / WORD_BITS);
    localparam int AW = $clog2(TOTAL_WORDS);

    logic [GS_W-1:0]  r_group_size;
    logic [TC_W-1:0]  r_total_count;
    logic [NUM_W-1:0] r_number_base;
    logic [NUM_W-1:0] r_lowest_freeable;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [NUM_W-1:0]  alloc_number;
    logic [STAT_W-1:0] status;
    logic [GF_W-1:0]   group_free;
    logic [TF_W-1:0]   total_free;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size      <= GS_W'(8192);
            r_total_count     <= TC_W'(65536);
            r_number_base     <= NUM_W'(1);
            r_lowest_freeable <= NUM_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_GROUP_SIZE: r_group_size      <= pwdata[GS_W-1:0];
                REG_TOTAL:      r_total_count     <= pwdata[TC_W-1:0];
                REG_BASE:       r_number_base     <= pwdata;
                REG_LOWEST:     r_lowest_freeable <= pwdata;
                default:        r_number_base     <= r_number_base;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GROUP_SIZE: prdata = 32'(r_group_size);
            REG_TOTAL:      prdata = 32'(r_total_count);
            REG_BASE:       prdata = r_number_base;
            REG_LOWEST:     prdata = r_lowest_freeable;
            default:        prdata = '0;
        endcase
    end

    // controller
    gba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // datapath
    gba_datapath #(
        .MAX_GROUP_BITS (MAX_GROUP_BITS),
        .MAX_GROUPS     (MAX_GROUPS),
        .WORD_BITS      (WORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (s_tuser),
        .i_item_number     (s_tdata[31:0]),
        .i_group_index     (s_tdata[34:32]),
        .i_word_index      (s_tdata[41:35]),
        .i_load_data       (s_tdata[105:42]),
        .i_group_size      (r_group_size),
        .i_total_count     (r_total_count),
        .i_number_base     (r_number_base),
        .i_lowest_freeable (r_lowest_freeable),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata),
        .o_alloc_number    (alloc_number),
        .o_status          (status),
        .o_group_free      (group_free),
        .o_total_free      (total_free)
    );

    // usage bitmap
    gba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TOTAL_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result word packing
    assign m_tdata = {1'b0, total_free, group_free, alloc_number};
    assign m_tuser = status;

endmodule
